[rtl/dse_pkg.sv]
// Shared types, constants and elaboration-time helpers for the DDS sine block.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package dse_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int PHASE_W         = 32;
    localparam int LEVEL_W         = 17;
    localparam int CFG_W           = 16;
    localparam int SINE_W          = 27;
    localparam int PROD_W          = LEVEL_W + 1 + SINE_W;
    localparam int SHIFT_TOTAL     = 30;
    localparam int WORD_W          = 16;
    localparam int FRAC_BITS       = 55;

    localparam logic [WORD_W-1:0] DAC_HEADER = 16'hB000;
    localparam logic [WORD_W-1:0] DAC_OFFSET = 16'd2048;
    localparam logic [63:0]       ROM_SCALE  = 64'd67076096;

    localparam logic [CFG_W-1:0] MAX_LEVEL_RST   = 16'd32768;
    localparam logic [CFG_W-1:0] ATTACK_STEP_RST = 16'd131;
    localparam logic [CFG_W-1:0] DECAY_STEP_RST  = 16'd131;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LEVEL   = 2'd0,
        CFG_ATTACK_STEP = 2'd1,
        CFG_DECAY_STEP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] max_level;
        logic [CFG_W-1:0] attack_step;
        logic [CFG_W-1:0] decay_step;
    } t_cfg;

    // (a * b) >> FRAC_BITS, low 64 bits kept
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC_BITS +: 64];
    endfunction

    // restoring divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], n[k]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // trunc(2047*32768*sin(idx*6.283/depth)) via fixed-point Taylor series
    function automatic logic signed [SINE_W-1:0] rom_entry(input int unsigned idx,
                                                           input int unsigned depth);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] dv;
        logic [63:0] mag;
        logic [63:0] v;
        logic        neg;
        num = 64'(idx) * 64'd6283;
        den = 64'd1000 * 64'(depth);
        q   = '0;
        r   = num;
        while (r >= den) begin
            r = r - den;
            q = q + 64'd1;
        end
        x = q << FRAC_BITS;
        for (int b = FRAC_BITS - 1; b >= 0; b--) begin
            r = r << 1;
            if (r >= den) begin
                r    = r - den;
                x[b] = 1'b1;
            end
        end
        x2   = mul_shift(x, x);
        term = x;
        sum  = x;
        n    = 64'd1;
        neg  = 1'b1;
        while (term != 64'd0 && n < 64'd200) begin
            dv   = (n + 64'd1) * (n + 64'd2);
            term = udiv64(term, dv);
            term = mul_shift(term, x2);
            n    = n + 64'd2;
            if (neg) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
            neg = !neg;
        end
        mag = sum[63] ? (64'd0 - sum) : sum;
        v   = mul_shift(mag, ROM_SCALE);
        return sum[63] ? SINE_W'(64'd0 - v) : SINE_W'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/dds_sine_with_envelope.sv]
// DDS sine generator with linear attack/decay envelope, DAC word output.
// Pipeline stages in order: table read, multiply, pack, each registered.
// Throughput: one beat per cycle; a stalled output holds its word while
// earlier stages keep filling until the three-stage pipeline is full.
// Reset: phase and envelope cleared, registers to defaults, pipeline empty;
// input and register writes are held off while reset is asserted.
// Depends on dse_pkg, dse_osc, dse_rom, dse_out.
`default_nettype none

module dds_sine_with_envelope #(
    parameter int TABLE_DEPTH = dse_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_tone_on,
    input  wire logic [dse_pkg::PHASE_W-1:0]         i_phase_step,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [dse_pkg::WORD_W-1:0]               o_dac_word,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dse_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    dse_pkg::t_cfg                         r_cfg;
    logic                                  w_ready;
    logic                                  w_load;
    logic [AW-1:0]                         w_addr;
    logic [dse_pkg::LEVEL_W-1:0]           w_env;
    logic signed [dse_pkg::SINE_W-1:0]     w_sine;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level   <= dse_pkg::MAX_LEVEL_RST;
            r_cfg.attack_step <= dse_pkg::ATTACK_STEP_RST;
            r_cfg.decay_step  <= dse_pkg::DECAY_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dse_pkg::CFG_MAX_LEVEL:   r_cfg.max_level   <= i_cfg_data;
                dse_pkg::CFG_ATTACK_STEP: r_cfg.attack_step <= i_cfg_data;
                dse_pkg::CFG_DECAY_STEP:  r_cfg.decay_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = !w_ready || !i_rst_n;
    assign w_load  = i_valid && !o_stall;

    dse_osc #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_osc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_load       (w_load),
        .i_tone_on    (i_tone_on),
        .i_phase_step (i_phase_step),
        .o_addr       (w_addr),
        .o_env        (w_env)
    );

    dse_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (w_load),
        .i_addr  (w_addr),
        .o_data  (w_sine)
    );

    dse_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_env      (w_env),
        .i_sine     (w_sine),
        .i_stall    (i_stall),
        .o_ready    (w_ready),
        .o_valid    (o_valid),
        .o_dac_word (o_dac_word)
    );

endmodule

`default_nettype wire

[rtl/dse_rom.sv]
// Sine lookup table, built at elaboration, with a registered read port.
// Depends on dse_pkg.
`default_nettype none

module dse_rom #(
    parameter int TABLE_DEPTH = dse_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]        i_addr,
    output logic signed [dse_pkg::SINE_W-1:0]          o_data
);

    logic signed [dse_pkg::SINE_W-1:0] w_rom [TABLE_DEPTH];
    logic signed [dse_pkg::SINE_W-1:0] r_data;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        localparam logic signed [dse_pkg::SINE_W-1:0] Entry =
            dse_pkg::rom_entry(g, TABLE_DEPTH);
        assign w_rom[g] = Entry;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/dse_osc.sv]
// Phase accumulator and linear attack/decay envelope, plus table address.
// Depends on dse_pkg.
`default_nettype none

module dse_osc #(
    parameter int TABLE_DEPTH = dse_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dse_pkg::t_cfg                       i_cfg,
    input  wire logic                                i_load,
    input  wire logic                                i_tone_on,
    input  wire logic [dse_pkg::PHASE_W-1:0]         i_phase_step,
    output logic [$clog2(TABLE_DEPTH)-1:0]           o_addr,
    output logic [dse_pkg::LEVEL_W-1:0]              o_env
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = dse_pkg::PHASE_W + $clog2(TABLE_DEPTH + 1);

    logic [dse_pkg::PHASE_W-1:0] r_acc;
    logic [dse_pkg::PHASE_W-1:0] n_acc;
    logic [dse_pkg::LEVEL_W-1:0] r_env;
    logic [dse_pkg::LEVEL_W-1:0] n_env;
    logic [dse_pkg::LEVEL_W:0]   w_rise;
    logic [dse_pkg::LEVEL_W:0]   w_ceil;
    logic [MW-1:0]               w_scaled;

    assign w_ceil = (dse_pkg::LEVEL_W + 1)'(i_cfg.max_level);
    assign w_rise = (dse_pkg::LEVEL_W + 1)'(r_env) +
                    (dse_pkg::LEVEL_W + 1)'(i_cfg.attack_step);

    always_comb begin
        n_env = r_env;
        if (i_tone_on) begin
            if ((dse_pkg::LEVEL_W + 1)'(r_env) < w_ceil) begin
                n_env = (w_rise > w_ceil) ? dse_pkg::LEVEL_W'(w_ceil)
                                          : dse_pkg::LEVEL_W'(w_rise);
            end
        end else begin
            if (r_env != '0) begin
                n_env = (r_env <= dse_pkg::LEVEL_W'(i_cfg.decay_step)) ? '0
                      : r_env - dse_pkg::LEVEL_W'(i_cfg.decay_step);
            end
        end
    end

    assign n_acc    = r_acc + i_phase_step;
    assign w_scaled = MW'(n_acc) * MW'(TABLE_DEPTH);
    assign o_addr   = w_scaled[dse_pkg::PHASE_W +: AW];
    assign o_env    = r_env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_env <= '0;
        end else if (i_load) begin
            r_acc <= n_acc;
            r_env <= n_env;
        end
    end

endmodule

`default_nettype wire

[rtl/dse_out.sv]
// Scale, offset and pack pipeline with per-stage valid and bubble collapse.
// Depends on dse_pkg.
`default_nettype none

module dse_out (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_load,
    input  wire logic [dse_pkg::LEVEL_W-1:0]          i_env,
    input  wire logic signed [dse_pkg::SINE_W-1:0]    i_sine,
    input  wire logic                                 i_stall,
    output logic                                      o_ready,
    output logic                                      o_valid,
    output logic [dse_pkg::WORD_W-1:0]                o_dac_word
);

    logic                                    r_v1;
    logic                                    r_v2;
    logic                                    r_v3;
    logic signed [dse_pkg::PROD_W-1:0]       r_prod;
    logic signed [dse_pkg::PROD_W-1:0]       w_prod;
    logic [dse_pkg::WORD_W-1:0]              r_word;
    logic [dse_pkg::WORD_W-1:0]              w_low;
    logic                                    w_rdy2;
    logic                                    w_rdy3;

    assign w_rdy3  = !r_v3 || !i_stall;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = !r_v1 || w_rdy2;

    assign w_prod = $signed({1'b0, i_env}) * i_sine;
    // floor shift by 2^30, low 16 bits
    assign w_low  = {r_prod[dse_pkg::PROD_W-1],
                     r_prod[dse_pkg::PROD_W-1:dse_pkg::SHIFT_TOTAL]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (i_load) begin
                r_v1 <= 1'b1;
            end else if (w_rdy2) begin
                r_v1 <= 1'b0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_prod <= w_prod;
        end
        if (w_rdy3 && r_v2) begin
            r_word <= (w_low + dse_pkg::DAC_OFFSET) | dse_pkg::DAC_HEADER;
        end
    end

    assign o_valid    = r_v3;
    assign o_dac_word = r_word;

endmodule

`default_nettype wire
